FILE: src/ccp_pkg.sv
// Shared types, codes and calendar functions for the calendar clock.
package ccp_pkg;

  localparam logic [1:0] ACT_TICK = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  localparam logic [11:0] YEAR_MIN   = 12'd1970;
  localparam logic [11:0] YEAR_MAX   = 12'd2099;
  localparam logic [11:0] YEAR_SAT   = 12'd4095;
  localparam logic [11:0] YEAR_RESET = 12'd2026;
  localparam logic [15:0] TPS_RESET  = 16'd100;

  localparam int DATA_W = 40;

  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } ccp_time_t;

  function automatic logic is_leap(input logic [11:0] y);
    logic [22:0] prod;
    logic [7:0]  q;
    logic [11:0] r;
    prod = {11'd0, y} * 23'd1311;
    q    = prod[22:15];
    r    = y - (({4'd0, q} << 4) + ({4'd0, q} << 3) + {4'd0, q});
    return (y[1:0] == 2'd0) && ((r != 12'd0) || (y[3:0] == 4'd0));
  endfunction

  function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] d;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
      4'd2:                                       d = is_leap(y) ? 5'd29 : 5'd28;
      default:                                    d = 5'd30;
    endcase
    return d;
  endfunction

endpackage

FILE: src/ccp_time_core.sv
// Time-of-day and calendar state with tick prescaler, set and carry logic.
module ccp_time_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  logic [1:0]       action,
  input  ccp_pkg::ccp_time_t set_time,
  input  logic [15:0]      tps,
  output ccp_pkg::ccp_time_t time_nxt,
  output logic             pulse_nxt
);
  import ccp_pkg::*;

  ccp_time_t   time_r;
  logic [15:0] phase_r;
  logic [15:0] phase_nxt;
  logic [15:0] tps_eff;
  logic [16:0] phase_inc;
  ccp_time_t   adv;
  ccp_time_t   setv;
  logic [4:0]  md_cur;
  logic [4:0]  md_set;

  assign tps_eff   = (tps == 16'd0) ? 16'd1 : tps;
  assign phase_inc = {1'b0, phase_r} + 17'd1;
  assign md_cur    = month_days(time_r.year, time_r.month);

  always_comb begin
    adv = time_r;
    if (time_r.second < 6'd59) begin
      adv.second = time_r.second + 6'd1;
    end else begin
      adv.second = 6'd0;
      if (time_r.minute < 6'd59) begin
        adv.minute = time_r.minute + 6'd1;
      end else begin
        adv.minute = 6'd0;
        if (time_r.hour < 5'd23) begin
          adv.hour = time_r.hour + 5'd1;
        end else begin
          adv.hour = 5'd0;
          if (time_r.day < md_cur) begin
            adv.day = time_r.day + 5'd1;
          end else begin
            adv.day = 5'd1;
            if (time_r.month < 4'd12) begin
              adv.month = time_r.month + 4'd1;
            end else begin
              adv.month = 4'd1;
              if (time_r.year < YEAR_SAT) begin
                adv.year = time_r.year + 12'd1;
              end
            end
          end
        end
      end
    end
  end

  always_comb begin
    setv.year   = (set_time.year < YEAR_MIN) ? YEAR_MIN :
                  (set_time.year > YEAR_MAX) ? YEAR_MAX : set_time.year;
    setv.month  = (set_time.month == 4'd0) ? 4'd1 :
                  (set_time.month > 4'd12) ? 4'd12 : set_time.month;
    md_set      = month_days(setv.year, setv.month);
    setv.day    = (set_time.day == 5'd0) ? 5'd1 :
                  (set_time.day > md_set) ? md_set : set_time.day;
    setv.hour   = (set_time.hour > 5'd23) ? 5'd23 : set_time.hour;
    setv.minute = (set_time.minute > 6'd59) ? 6'd59 : set_time.minute;
    setv.second = (set_time.second > 6'd59) ? 6'd59 : set_time.second;
  end

  always_comb begin
    time_nxt  = time_r;
    phase_nxt = phase_r;
    pulse_nxt = 1'b0;
    case (action)
      ACT_TICK: begin
        if (phase_inc >= {1'b0, tps_eff}) begin
          phase_nxt = 16'd0;
          time_nxt  = adv;
          pulse_nxt = 1'b1;
        end else begin
          phase_nxt = phase_inc[15:0];
        end
      end
      ACT_SET: begin
        time_nxt  = setv;
        phase_nxt = 16'd0;
      end
      default: begin
        time_nxt  = time_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= 16'd0;
      time_r.year   <= YEAR_RESET;
      time_r.month  <= 4'd1;
      time_r.day    <= 5'd1;
      time_r.hour   <= 5'd12;
      time_r.minute <= 6'd0;
      time_r.second <= 6'd0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      time_r  <= time_nxt;
    end
  end

endmodule

FILE: src/calendar_clock_with_prescaler.sv
// Calendar clock top level: input register, time core and result register.
// A transaction goes from the input register through the core to the result register.
// One transaction per cycle unless out_tready stalls; the carry chain is combinational.
// Reset (rst_n low, synchronous): 2026-01-01 12:00:00, prescaler 0,
// ticks_per_second 100, both pipeline registers empty.
module calendar_clock_with_prescaler (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // set_year[11:0], set_month[15:12], set_day[20:16], set_hour[25:21],
  // set_minute[31:26], set_second[37:32], zero pad [39:38]
  input  logic [ccp_pkg::DATA_W-1:0] in_tdata,
  // action[1:0]
  input  logic [1:0]                 in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // year_now[11:0], month_now[15:12], day_now[20:16], hour_now[25:21],
  // minute_now[31:26], second_now[37:32], zero pad [39:38]
  output logic [ccp_pkg::DATA_W-1:0] out_tdata,
  // second_pulse[0]
  output logic                       out_tuser,
  input  logic                       cfg_tvalid,
  output logic                       cfg_tready,
  // ticks_per_second[15:0]
  input  logic [15:0]                cfg_tdata
);
  import ccp_pkg::*;

  logic        in_valid_r;
  logic [1:0]  in_user_r;
  logic [37:0] in_data_r;
  logic        out_valid_r;
  ccp_time_t   out_time_r;
  logic        out_pulse_r;
  logic [15:0] tps_r;
  logic        step_en;
  ccp_time_t   set_time;
  ccp_time_t   time_nxt;
  logic        pulse_nxt;

  assign step_en    = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !in_valid_r || step_en;
  assign cfg_tready = 1'b1;

  assign set_time.year   = in_data_r[11:0];
  assign set_time.month  = in_data_r[15:12];
  assign set_time.day    = in_data_r[20:16];
  assign set_time.hour   = in_data_r[25:21];
  assign set_time.minute = in_data_r[31:26];
  assign set_time.second = in_data_r[37:32];

  ccp_time_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (step_en),
    .action   (in_user_r),
    .set_time (set_time),
    .tps      (tps_r),
    .time_nxt (time_nxt),
    .pulse_nxt(pulse_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (cfg_tvalid && cfg_tready) begin
      tps_r <= cfg_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_user_r <= in_tuser;
      in_data_r <= in_tdata[37:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_en) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_time_r  <= time_nxt;
      out_pulse_r <= pulse_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_pulse_r;
  assign out_tdata  = {2'b00, out_time_r.second, out_time_r.minute, out_time_r.hour,
                       out_time_r.day, out_time_r.month, out_time_r.year};

endmodule
